[design/tli_pkg.sv]
`default_nettype none
package tli_pkg;
   localparam int TablePoints = 16;
   localparam int IdxW = 4;
   localparam int ValW = 32;
   localparam int CntW = 5;
   localparam int QueueDepth = 2;
   localparam int PW = 2*ValW;
   localparam int DW = PW + 1;

   typedef enum logic [0:0] {CMD_WRITE = 1'b0, CMD_QUERY = 1'b1} cmd_type;
   typedef enum logic [0:0] {CSR_EXTRAP = 1'b0, CSR_POINTS = 1'b1} csr_idx_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [IdxW-1:0]       idx;
      logic signed [ValW-1:0] xv;
      logic signed [ValW-1:0] yv;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_FETCH, ST_MUL, ST_DIV, ST_SUM, ST_OUT
   } state_type;
endpackage
`default_nettype wire

[design/tli_queue.sv]
`default_nettype none
module tli_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tli_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output tli_pkg::item_type      out_item
);
   import tli_pkg::*;
   item_type  mem_ff [QueueDepth];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

[design/tli_engine.sv]
`default_nettype none
module tli_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              extrap_mode,
   input  wire logic [tli_pkg::CntW-1:0] points_in_use,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire tli_pkg::item_type in_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [tli_pkg::ValW-1:0] rsp_y_result,
   output logic                   rsp_degenerate_segment,
   output logic                   rsp_saturated
);
   import tli_pkg::*;

   logic [ValW-1:0] xt [TablePoints];
   logic [ValW-1:0] yt [TablePoints];

   state_type st_ff, st_in;
   logic [IdxW-1:0] k_ff, k_in, j_ff, j_in, last;
   logic [ValW-1:0] q_ff, x0_ff, x1_ff, y0_ff, y1_ff;
   logic [ValW:0]   mdx_ff, mdq_ff, mdy_ff;
   logic            neg_ff;
   logic [PW-1:0]   num_ff;
   logic [ValW:0]   rem_ff;
   logic [PW-1:0]   quo_ff;
   logic [6:0]      cnt_ff;
   logic [ValW-1:0] res_ff;
   logic            deg_ff, sat_ff;
   logic [CntW-1:0] nclamp;
   logic            ge;

   always_comb begin
      if (points_in_use < CntW'(2)) nclamp = CntW'(2);
      else if (points_in_use > CntW'(TablePoints)) nclamp = CntW'(TablePoints);
      else nclamp = points_in_use;
      last = IdxW'(nclamp - CntW'(1));
      ge = !($signed(xt[k_ff]) < $signed(q_ff));
   end

   function automatic logic [ValW:0] sdiff(input logic [ValW-1:0] a, input logic [ValW-1:0] b);
      logic signed [ValW:0] d;
      d = $signed({a[ValW-1], a}) - $signed({b[ValW-1], b});
      return d;
   endfunction

   logic [ValW:0] dx, dq, dy;
   logic [DW:0]   trial;
   logic [ValW+1:0] rsh;
   logic signed [PW+1:0] sum;
   logic [PW:0] sq;

   always_comb begin
      dx = sdiff(x1_ff, x0_ff);
      dq = sdiff(q_ff, x0_ff);
      dy = sdiff(y1_ff, y0_ff);
      rsh = {rem_ff, num_ff[PW-1]};
      trial = {{(DW-ValW-1){1'b0}}, rsh} - {{(DW-ValW){1'b0}}, mdx_ff};
      sq = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
      sum = $signed({{(PW+2-ValW){y0_ff[ValW-1]}}, y0_ff}) + $signed({sq[PW], sq});
   end

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      j_in = j_ff;
      in_ready = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid && in_item.cmd == CMD_QUERY) begin
               st_in = ST_SEARCH;
               k_in = '0;
            end
         end
         ST_SEARCH: begin
            if (ge || k_ff == last) begin
               j_in = k_ff;
               if (!extrap_mode && (k_ff == '0 || !ge)) st_in = ST_OUT;
               else st_in = ST_FETCH;
            end else k_in = k_ff + IdxW'(1);
         end
         ST_FETCH: st_in = ST_MUL;
         ST_MUL:   st_in = (dx == '0) ? ST_OUT : ST_DIV;
         ST_DIV:   if (cnt_ff == 7'd0) st_in = ST_SUM;
         ST_SUM:   st_in = ST_OUT;
         ST_OUT:   if (rsp_ready) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_y_result = res_ff;
   assign rsp_degenerate_segment = deg_ff;
   assign rsp_saturated = sat_ff;

   logic [IdxW-1:0] ja;
   assign ja = (j_ff == '0) ? IdxW'(1) : j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      k_ff <= k_in;
      j_ff <= j_in;
      if (st_ff == ST_IDLE && in_valid) begin
         q_ff <= in_item.xv;
         if (in_item.cmd == CMD_WRITE) begin
            xt[in_item.idx] <= in_item.xv;
            yt[in_item.idx] <= in_item.yv;
         end
      end
      if (st_ff == ST_SEARCH && (ge || k_ff == last)) begin
         if (!extrap_mode && (k_ff == '0 || !ge)) begin
            res_ff <= yt[k_ff];
            deg_ff <= 1'b0;
            sat_ff <= 1'b0;
         end
      end
      if (st_ff == ST_FETCH) begin
         x0_ff <= xt[ja - IdxW'(1)];
         x1_ff <= xt[ja];
         y0_ff <= yt[ja - IdxW'(1)];
         y1_ff <= yt[ja];
      end
      if (st_ff == ST_MUL) begin
         mdx_ff <= dx[ValW] ? -dx : dx;
         mdq_ff <= dq[ValW] ? -dq : dq;
         mdy_ff <= dy[ValW] ? -dy : dy;
         neg_ff <= dx[ValW] ^ dq[ValW] ^ dy[ValW];
         num_ff <= '0;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= 7'(PW);
         if (dx == '0) begin
            res_ff <= y0_ff;
            deg_ff <= 1'b1;
            sat_ff <= 1'b0;
         end
      end
      if (st_ff == ST_DIV) begin
         if (cnt_ff == 7'(PW)) begin
            num_ff <= (PW'(mdy_ff[ValW-1:0]) * PW'(mdq_ff[ValW-1:0])) |
                      (mdy_ff[ValW] ? PW'(mdq_ff) << ValW : '0) |
                      (mdq_ff[ValW] ? PW'(mdy_ff) << ValW : '0);
            cnt_ff <= cnt_ff - 7'd1;
         end else begin
            num_ff <= num_ff << 1;
            if (!trial[DW]) begin
               rem_ff <= trial[ValW:0];
               quo_ff <= {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_ff <= rsh[ValW:0];
               quo_ff <= {quo_ff[PW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 7'd1;
         end
      end
      if (st_ff == ST_SUM) begin
         deg_ff <= 1'b0;
         if (sum > $signed((PW+2)'({1'b0, {(ValW-1){1'b1}}}))) begin
            res_ff <= {1'b0, {(ValW-1){1'b1}}}; sat_ff <= 1'b1;
         end else if (sum < -$signed((PW+2)'({1'b1, {(ValW-1){1'b0}}}))) begin
            res_ff <= {1'b1, {(ValW-1){1'b0}}}; sat_ff <= 1'b1;
         end else begin
            res_ff <= sum[ValW-1:0]; sat_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

[design/table_linear_interpolator_unit.sv]
// Piecewise linear table interpolator, Q16.16. Write words load breakpoints, query words
// return one result word. Words pass a two-entry queue into a sequential engine: a query
// goes through an accept state, a linear search of 1 to 16 breakpoints, a fetch and a setup
// state, the bit-serial restoring divider, a sum state and an output state; held and
// zero-width results skip the divider. No result for writes.
`default_nettype none
module table_linear_interpolator_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [4:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [3:0]  req_point_index,
   input  wire logic signed [31:0] req_x_value,
   input  wire logic signed [31:0] req_y_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_y_result,
   output logic             rsp_degenerate_segment,
   output logic             rsp_saturated
);
   import tli_pkg::*;
   logic extrap_ff;
   logic [CntW-1:0] points_ff;
   item_type req_item, q_item;
   logic q_valid, q_ready;
   logic [ValW-1:0] yres;

   always_ff @(posedge clock) begin
      if (reset) begin
         extrap_ff <= 1'b0;
         points_ff <= CntW'(2);
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_EXTRAP: extrap_ff <= csr_write_data[0];
            CSR_POINTS: points_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_item = '{cmd: cmd_type'(req_command), idx: req_point_index,
                       xv: req_x_value, yv: req_y_value};

   tli_queue u_queue (
      .clock, .reset, .in_valid(req_valid), .in_ready(req_ready), .in_item(req_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   tli_engine u_engine (
      .clock, .reset, .extrap_mode(extrap_ff), .points_in_use(points_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .rsp_valid, .rsp_ready, .rsp_y_result(yres),
      .rsp_degenerate_segment, .rsp_saturated
   );
   assign rsp_y_result = $signed(yres);
endmodule
`default_nettype wire

[design/tli_checker.sv]
`default_nettype none
module tli_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [31:0] rsp_y_result,
   input wire logic rsp_degenerate_segment,
   input wire logic rsp_saturated
);
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_degenerate_segment && rsp_saturated)) else $error("both flags");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_y_result == 32'h7fffffff ||
      rsp_y_result == 32'h80000000) else $error("sat value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_result)) else $error("hold");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid) else $error("reset");
endmodule
bind table_linear_interpolator_unit tli_checker u_chk (.*);
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import tli_pkg::*;

   class interp_scoreboard;
      logic signed [31:0] xt[16];
      logic signed [31:0] yt[16];
      bit                 extrap;
      int                 npts;
      logic signed [31:0] exp_y[$];
      bit                 exp_deg[$];
      bit                 exp_sat[$];
      int                 errors;

      function new();
         extrap = 0;
         npts = 2;
         errors = 0;
      endfunction

      function void note_word(cmd_type c, logic [3:0] idx, logic signed [31:0] xv,
                              logic signed [31:0] yv);
         int n, j;
         logic signed [31:0] x0, x1, y0, y1, ry;
         logic signed [33:0] dx, dq, dy;
         logic signed [67:0] prod, quo;
         logic signed [69:0] sum;
         bit deg, sat;
         if (c == CMD_WRITE) begin
            xt[idx] = xv;
            yt[idx] = yv;
            return;
         end
         n = npts < 2 ? 2 : (npts > 16 ? 16 : npts);
         j = n - 1;
         for (int k = 0; k < n; k++)
            if (!(xt[k] < xv)) begin
               j = k;
               break;
            end
         deg = 0;
         sat = 0;
         if (!extrap && j == 0) ry = yt[0];
         else if (!extrap && xt[j] < xv) ry = yt[j];
         else begin
            if (j == 0) j = 1;
            x0 = xt[j-1]; x1 = xt[j]; y0 = yt[j-1]; y1 = yt[j];
            if (x0 == x1) begin
               ry = y0;
               deg = 1;
            end else begin
               dx = x1 - x0;
               dq = xv - x0;
               dy = y1 - y0;
               prod = dy * dq;
               quo = prod / dx;
               sum = y0 + quo;
               if (sum > 70'sd2147483647) begin
                  ry = 32'sh7fffffff;
                  sat = 1;
               end else if (sum < -70'sd2147483648) begin
                  ry = 32'sh80000000;
                  sat = 1;
               end else ry = sum[31:0];
            end
         end
         exp_y = {exp_y, ry};
         exp_deg = {exp_deg, deg};
         exp_sat = {exp_sat, sat};
      endfunction

      function void check_word(logic signed [31:0] y, logic d, logic s);
         if (exp_y.size() == 0) begin
            $error("unexpected result word y=%0d", y);
            errors++;
            return;
         end
         if (y !== exp_y[0]) begin
            $error("y_result exp %0d got %0d", exp_y[0], y);
            errors++;
         end
         if (d !== exp_deg[0]) begin
            $error("degenerate_segment exp %0d got %0d", exp_deg[0], d);
            errors++;
         end
         if (s !== exp_sat[0]) begin
            $error("saturated exp %0d got %0d", exp_sat[0], s);
            errors++;
         end
         void'(exp_y.pop_front());
         void'(exp_deg.pop_front());
         void'(exp_sat.pop_front());
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_write_enable = 0;
   logic [0:0] csr_index = 0;
   logic [4:0] csr_write_data = 0;
   logic req_valid = 0, req_ready;
   logic req_command = 0;
   logic [3:0] req_point_index = 0;
   logic signed [31:0] req_x_value = 0, req_y_value = 0;
   logic rsp_valid, rsp_ready = 0;
   logic signed [31:0] rsp_y_result;
   logic rsp_degenerate_segment, rsp_saturated;

   interp_scoreboard sb = new();
   bit quiet = 0;
   bit hold_rsp = 0;

   table_linear_interpolator_unit u_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_y_result, rsp_degenerate_segment, rsp_saturated);
   end

   initial begin : rsp_side
      int gap;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic csr_write(csr_idx_type idx, logic [4:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      if (idx == CSR_EXTRAP) sb.extrap = val[0];
      else sb.npts = val;
   endtask

   task automatic send_word(cmd_type c, logic [3:0] idx, logic signed [31:0] xv,
                            logic signed [31:0] yv);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= c;
      req_point_index <= idx;
      req_x_value <= xv;
      req_y_value <= yv;
      do @(posedge clock); while (!req_ready);
      sb.note_word(c, idx, xv, yv);
   endtask

   task automatic drain();
      int guard;
      req_valid <= 0;
      guard = 0;
      while (sb.exp_y.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_val(int sel);
      case (sel)
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_table(int n, bit sorted, bit wide);
      logic signed [31:0] xv;
      xv = wide ? 32'sh80000000 + $urandom_range(0, 1000) : $urandom_range(0, 4000) - 2000;
      for (int i = 0; i < n; i++) begin
         if (!sorted && $urandom_range(0, 1)) xv = rand_val($urandom_range(0, 4));
         else if ($urandom_range(0, 7) == 0) xv = xv;
         else if (wide) xv = xv + $urandom_range(1, 32'h0fffffff);
         else xv = xv + $urandom_range(1, 3000);
         send_word(CMD_WRITE, i[3:0], xv, rand_val($urandom_range(0, 4)));
      end
   endtask

   task automatic run_queries(int cnt, bit wide);
      int k;
      for (int i = 0; i < cnt; i++) begin
         k = $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0)
            send_word(CMD_WRITE, k[3:0], rand_val($urandom_range(0, 4)), $urandom);
         else if ($urandom_range(0, 2) == 0)
            send_word(CMD_QUERY, 4'($urandom), sb.xt[k], $urandom);
         else
            send_word(CMD_QUERY, 4'($urandom), wide ? $urandom :
                      rand_val($urandom_range(0, 2) ? 2 : $urandom_range(0, 3)), $urandom);
      end
   endtask

   initial begin : stim
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      csr_write(CSR_POINTS, 5'd4);
      send_word(CMD_WRITE, 4'd0, -32'sd65536, 32'sh7fffffff);
      send_word(CMD_WRITE, 4'd1, 32'sd0, 32'sh80000000);
      send_word(CMD_WRITE, 4'd2, 32'sd0, 32'sd100);
      send_word(CMD_WRITE, 4'd3, 32'sd131072, -32'sd5);
      send_word(CMD_QUERY, 4'd15, 32'sh80000000, 32'sh7fffffff);
      send_word(CMD_QUERY, 4'd0, 32'sh7fffffff, 0);
      send_word(CMD_QUERY, 4'd0, -32'sd100, 0);
      send_word(CMD_QUERY, 4'd0, 32'sd0, 0);
      send_word(CMD_QUERY, 4'd0, 32'sd65536, 0);
      drain();
      csr_write(CSR_EXTRAP, 5'd1);
      send_word(CMD_QUERY, 4'd0, 32'sh80000000, 0);
      send_word(CMD_QUERY, 4'd0, 32'sh7fffffff, 0);
      send_word(CMD_QUERY, 4'd0, -32'sd100, 0);
      send_word(CMD_QUERY, 4'd0, 32'sd0, 0);
      send_word(CMD_QUERY, 4'd0, 32'sd1000, 0);
      drain();
      csr_write(CSR_POINTS, 5'd0);
      send_word(CMD_QUERY, 4'd0, 32'sd5, 0);
      drain();
      csr_write(CSR_POINTS, 5'd31);
      // 16 points written below before any query
      load_table(16, 1, 0);
      send_word(CMD_QUERY, 4'd0, 32'sd0, 0);
      drain();
      // random phases
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_EXTRAP, 5'($urandom_range(0, 1)));
         csr_write(CSR_POINTS, 5'(ph == 0 ? 2 : (ph == 1 ? 16 : $urandom_range(0, 31))));
         load_table(16, ph != 5, ph == 3 || ph == 6);
         if (ph == 4) hold_rsp = 1;
         if (ph == 7) quiet = 1;
         run_queries(86, ph == 3 || ph == 6);
         drain();
      end
      if (sb.errors == 0 && sb.exp_y.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
`default_nettype wire
